[sv/fgsc_pkg.sv]
// Package for the fuel grid scan with centre seed.
// Holds the status codes, the queue entry type and the fuel code table.
// Depends on nothing; every other file imports it.
package fgsc_pkg;

  localparam int DimW       = 13;
  localparam int MaxDim     = 4096;
  localparam int CellsW     = 26;
  localparam int IndexW     = 25;
  localparam int RowW       = 25;
  localparam int ColW       = 12;
  localparam int MagW       = 14;
  localparam int SqW        = 2 * MagW;
  localparam int DistW      = 27;
  localparam int CountW     = 25;
  localparam int BadW       = 24;
  localparam int CodeW      = 16;
  localparam int Combustible = 100;
  localparam logic [CellsW-1:0] CellLimit = CellsW'(16000000);
  localparam logic [IndexW-1:0] IndexMax  = '1;
  localparam logic [DistW-1:0]  DistInit  = '1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_NO_FUEL = 2'd2,
    ST_COUNT   = 2'd3
  } fgsc_status_t;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } fgsc_reg_t;

  typedef struct packed {
    logic              bad;
    logic              cnt_valid;
    logic              cnt_comb;
    logic              far;
    logic [ColW-1:0]   col;
    logic [ColW-1:0]   row;
    logic [MagW-1:0]   mag_x;
    logic [MagW-1:0]   mag_y;
    logic [BadW-1:0]   index;
    logic              last;
    logic              too_big;
    logic              mismatch;
  } fgsc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fgsc_q_stat_t;

  function automatic logic fgsc_code_known(input logic [CodeW-1:0] code);
    logic known;
    case (code)
      16'd0, 16'd91, 16'd92, 16'd93, 16'd98,
      16'd102, 16'd104, 16'd106, 16'd107, 16'd108, 16'd109,
      16'd142, 16'd143, 16'd145, 16'd147, 16'd148, 16'd149,
      16'd161, 16'd162, 16'd163, 16'd165, 16'd183: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

  function automatic logic [DimW-1:0] fgsc_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] d;
    if (v == '0) begin
      d = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      d = DimW'(MaxDim);
    end else begin
      d = v;
    end
    return d;
  endfunction

endpackage

[sv/fgsc_ifs.sv]
// Stream interfaces for the fuel grid scan: cell input and scan result.
// Depends on fgsc_pkg for the field widths.
interface fgsc_in_if;
  import fgsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] fuel_code;
  logic             last_cell;
  modport source (output valid, output fuel_code, output last_cell, input ready);
  modport sink (input valid, input fuel_code, input last_cell, output ready);
endinterface

interface fgsc_out_if;
  import fgsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CountW-1:0] valid_count;
  logic [CountW-1:0] combustible_count;
  logic [ColW-1:0]   seed_x;
  logic [ColW-1:0]   seed_y;
  logic [BadW-1:0]   bad_index;
  modport source (output valid, output status, output valid_count, output combustible_count,
                  output seed_x, output seed_y, output bad_index, input ready);
  modport sink (input valid, input status, input valid_count, input combustible_count,
                input seed_x, input seed_y, input bad_index, output ready);
endinterface

[sv/fgsc_front.sv]
// Front part of the fuel grid scan: accepts cells, tracks the raster position,
// classifies each code and works out the centre offsets. Depends on fgsc_pkg.
module fgsc_front import fgsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [DimW-1:0]  grid_width,
  input  logic [DimW-1:0]  grid_height,
  fgsc_in_if.sink          in_ch,
  input  fgsc_q_stat_t     q_stat,
  output logic             push,
  output fgsc_entry_t      push_data
);

  logic [ColW-1:0]   col;
  logic [ColW-1:0]   col_next;
  logic [RowW-1:0]   row;
  logic [RowW-1:0]   row_next;
  logic [IndexW-1:0] index;
  logic [IndexW-1:0] index_next;
  logic [DimW-1:0]   w;
  logic [DimW-1:0]   h;
  logic [CellsW-1:0] cells;
  logic              in_grid;
  logic              known;
  logic signed [ColW+2:0] dx;
  logic signed [RowW+2:0] dy;
  logic [ColW+2:0]   abs_x;
  logic [RowW+2:0]   abs_y;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    w       = fgsc_dim(grid_width);
    h       = fgsc_dim(grid_height);
    cells   = CellsW'(w) * CellsW'(h);
    in_grid = CellsW'(index) < cells;
    known   = fgsc_code_known(in_ch.fuel_code);
    dx      = $signed({2'b00, col, 1'b0}) - $signed((ColW+3)'(w)) + $signed((ColW+3)'(1));
    dy      = $signed({2'b00, row, 1'b0}) - $signed((RowW+3)'(h)) + $signed((RowW+3)'(1));
    abs_x   = dx[ColW+2] ? (ColW+3)'(-dx) : (ColW+3)'(dx);
    abs_y   = dy[RowW+2] ? (RowW+3)'(-dy) : (RowW+3)'(dy);
    col_next = col;
    row_next = row;
    if (in_grid) begin
      if ((DimW'(col) + DimW'(1)) >= w) begin
        col_next = '0;
        row_next = row + RowW'(1);
      end else begin
        col_next = col + ColW'(1);
      end
    end
    index_next = (index == IndexMax) ? index : index + IndexW'(1);

    push_data.bad       = in_grid && !known;
    push_data.cnt_valid = in_grid && known && (in_ch.fuel_code != '0);
    push_data.cnt_comb  = in_grid && known && (in_ch.fuel_code >= CodeW'(Combustible));
    push_data.far       = |abs_y[RowW+2:MagW];
    push_data.col       = col;
    push_data.row       = row[ColW-1:0];
    push_data.mag_x     = abs_x[MagW-1:0];
    push_data.mag_y     = abs_y[MagW-1:0];
    push_data.index     = index[BadW-1:0];
    push_data.last      = in_ch.last_cell;
    push_data.too_big   = cells > CellLimit;
    push_data.mismatch  = CellsW'(index_next) != cells;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      index <= '0;
    end else if (push) begin
      if (in_ch.last_cell) begin
        col   <= '0;
        row   <= '0;
        index <= '0;
      end else begin
        col   <= col_next;
        row   <= row_next;
        index <= index_next;
      end
    end
  end

endmodule

[sv/fgsc_queue.sv]
// Short queue of classified cells between the front and back parts.
// Depends on fgsc_pkg for the entry and status types.
module fgsc_queue import fgsc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  fgsc_entry_t  push_data,
  input  logic         pop,
  output fgsc_entry_t  pop_data,
  output fgsc_q_stat_t q_stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  fgsc_entry_t     slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign pop_data     = slots[rd_ptr];
  assign q_stat.full  = count == CntW'(DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[sv/fgsc_back.sv]
// Back part of the fuel grid scan: squares the offsets, keeps the totals and
// the nearest seed, and holds the result for transfer. Depends on fgsc_pkg.
module fgsc_back import fgsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  fgsc_q_stat_t q_stat,
  input  fgsc_entry_t  pop_data,
  output logic         pop,
  fgsc_out_if.source   out_ch
);

  logic              stall;
  logic              a_valid;
  fgsc_entry_t       a_ent;
  logic [SqW-1:0]    a_sqx;
  logic [SqW-1:0]    a_sqy;
  logic [SqW:0]      sum_sq;
  logic              closer;
  logic              take;

  logic [CountW-1:0] valid_total;
  logic [CountW-1:0] valid_total_next;
  logic [CountW-1:0] comb_total;
  logic [CountW-1:0] comb_total_next;
  logic [DistW-1:0]  best_dist;
  logic [ColW-1:0]   best_col;
  logic [ColW-1:0]   best_col_next;
  logic [ColW-1:0]   best_row;
  logic [ColW-1:0]   best_row_next;
  logic              err_seen;
  logic              err_seen_next;
  logic [BadW-1:0]   first_bad;
  logic [BadW-1:0]   first_bad_next;
  fgsc_status_t      status_next;

  logic              res_valid;
  fgsc_status_t      res_status;
  logic [CountW-1:0] res_valid_count;
  logic [CountW-1:0] res_comb_count;
  logic [ColW-1:0]   res_seed_x;
  logic [ColW-1:0]   res_seed_y;
  logic [BadW-1:0]   res_bad_index;

  assign stall = res_valid && !out_ch.ready && a_valid && a_ent.last;
  assign pop   = !q_stat.empty && !stall;
  assign take  = a_valid && !stall;

  assign out_ch.valid             = res_valid;
  assign out_ch.status            = res_status;
  assign out_ch.valid_count       = res_valid_count;
  assign out_ch.combustible_count = res_comb_count;
  assign out_ch.seed_x            = res_seed_x;
  assign out_ch.seed_y            = res_seed_y;
  assign out_ch.bad_index         = res_bad_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!stall) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      a_ent <= pop_data;
      a_sqx <= SqW'(pop_data.mag_x) * SqW'(pop_data.mag_x);
      a_sqy <= SqW'(pop_data.mag_y) * SqW'(pop_data.mag_y);
    end
  end

  always_comb begin
    sum_sq = (SqW+1)'(a_sqx) + (SqW+1)'(a_sqy);
    closer = a_ent.cnt_comb && !a_ent.far && (sum_sq < (SqW+1)'(best_dist));
    valid_total_next = valid_total + (a_ent.cnt_valid ? CountW'(1) : CountW'(0));
    comb_total_next  = comb_total + (a_ent.cnt_comb ? CountW'(1) : CountW'(0));
    best_col_next    = closer ? a_ent.col : best_col;
    best_row_next    = closer ? a_ent.row : best_row;
    err_seen_next    = err_seen || a_ent.bad;
    first_bad_next   = (a_ent.bad && !err_seen) ? a_ent.index : first_bad;
    if (a_ent.too_big) begin
      status_next = ST_COUNT;
    end else if (err_seen_next) begin
      status_next = ST_UNKNOWN;
    end else if (a_ent.mismatch) begin
      status_next = ST_COUNT;
    end else if (comb_total_next == '0) begin
      status_next = ST_NO_FUEL;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_total <= '0;
      comb_total  <= '0;
      best_dist   <= DistInit;
      best_col    <= '0;
      best_row    <= '0;
      err_seen    <= 1'b0;
      first_bad   <= '0;
    end else if (take) begin
      if (a_ent.last) begin
        valid_total <= '0;
        comb_total  <= '0;
        best_dist   <= DistInit;
        best_col    <= '0;
        best_row    <= '0;
        err_seen    <= 1'b0;
        first_bad   <= '0;
      end else begin
        valid_total <= valid_total_next;
        comb_total  <= comb_total_next;
        best_dist   <= closer ? sum_sq[DistW-1:0] : best_dist;
        best_col    <= best_col_next;
        best_row    <= best_row_next;
        err_seen    <= err_seen_next;
        first_bad   <= first_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && a_ent.last) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && a_ent.last) begin
      res_status      <= status_next;
      res_valid_count <= valid_total_next;
      res_comb_count  <= comb_total_next;
      res_seed_x      <= best_col_next;
      res_seed_y      <= best_row_next;
      res_bad_index   <= (status_next == ST_UNKNOWN) ? first_bad_next : '0;
    end
  end

endmodule

[sv/fuel_grid_scan_center_seed_core.sv]
// Fuel grid scan core: one fuel code per grid cell in raster order, one result
// for each grid on the cell marked last. The block accepts one cell every clock
// cycle for as long as the result side keeps up, and the result of a grid is
// registered once its last cell has passed through the queue between the
// classifying front and the accumulating back and through the squaring stage.
// While a result waits, the back goes on taking cells until the last cell of
// the next grid reaches it; the four-entry queue then takes up to four further
// cells before the input stalls. The grid width and height registers are taken
// straight from the write port and need no settling time; there is no start-up
// clearing pass.
module fuel_grid_scan_center_seed_core import fgsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [DimW-1:0] cfg_data,
  fgsc_in_if.sink         in_ch,
  fgsc_out_if.source      out_ch
);

  logic [DimW-1:0] grid_width;
  logic [DimW-1:0] grid_height;
  logic            push;
  fgsc_entry_t     push_data;
  logic            pop;
  fgsc_entry_t     pop_data;
  fgsc_q_stat_t    q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DimW'(1);
      grid_height <= DimW'(1);
    end else if (cfg_we) begin
      case (fgsc_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  fgsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .in_ch       (in_ch),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  fgsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  fgsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[sv/fgsc_checker.sv]
// Port-level checks for the fuel grid scan core, attached by a bind statement.
// Depends on fgsc_pkg for the status codes.
module fgsc_checker import fgsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [CountW-1:0] valid_count,
  input logic [CountW-1:0] combustible_count,
  input logic [ColW-1:0]   seed_x,
  input logic [ColW-1:0]   seed_y,
  input logic [BadW-1:0]   bad_index
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(seed_x)
      && $stable(seed_y) && $stable(valid_count))
    else $error("result changed while waiting for transfer");

  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_UNKNOWN) |-> bad_index == '0)
    else $error("bad index reported without an unknown code");

  a_ok_fuel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> combustible_count != '0)
    else $error("ok status with no combustible cell");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> combustible_count <= valid_count)
    else $error("more combustible cells than valid cells");

  a_no_seed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (combustible_count == '0) |-> (seed_x == '0) && (seed_y == '0))
    else $error("seed reported without a combustible cell");

endmodule

bind fuel_grid_scan_center_seed_core fgsc_checker u_fgsc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .status            (out_ch.status),
  .valid_count       (out_ch.valid_count),
  .combustible_count (out_ch.combustible_count),
  .seed_x            (out_ch.seed_x),
  .seed_y            (out_ch.seed_y),
  .bad_index         (out_ch.bad_index)
);

[dv/tb_fuel_grid_scan_center_seed_core.sv]
`timescale 1ns / 100ps
// Testbench for the fuel grid scan core: drives cell streams under several grid sizes,
// predicts each grid report in the testbench and compares it field by field.
// Depends on fgsc_pkg, the fgsc stream interfaces and fuel_grid_scan_center_seed_core.
module tb_fuel_grid_scan_center_seed_core;
  import fgsc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int StallCycles = 300;
  localparam logic [CodeW-1:0] FuelTable [22] = '{
    16'd0, 16'd91, 16'd92, 16'd93, 16'd98, 16'd102, 16'd104, 16'd106, 16'd107, 16'd108,
    16'd109, 16'd142, 16'd143, 16'd145, 16'd147, 16'd148, 16'd149, 16'd161, 16'd162,
    16'd163, 16'd165, 16'd183
  };

  typedef enum {MIX_CLEAN, MIX_NO_FUEL, MIX_NOISY} fuel_mix_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             last;
  } grid_cell_t;

  typedef struct {
    fgsc_status_t      status;
    logic [CountW-1:0] valid_count;
    logic [CountW-1:0] combustible_count;
    logic [ColW-1:0]   seed_x;
    logic [ColW-1:0]   seed_y;
    logic [BadW-1:0]   bad_index;
  } grid_report_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [0:0]      cfg_index = REG_GRID_WIDTH;
  logic [DimW-1:0] cfg_data = '0;

  fgsc_in_if  cells_if ();
  fgsc_out_if report_if ();

  fuel_grid_scan_center_seed_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (cells_if),
    .out_ch    (report_if)
  );

  always #10 clk = ~clk;

  grid_cell_t   pending_cells [$];
  grid_report_t due_reports [$];
  int           errors = 0;
  int           cycle_count = 0;
  int           cells_sent = 0;
  int           send_gap_pct = 0;
  int           take_gap_pct = 0;
  logic         pressure_on = 1'b0;
  logic         pressure_done = 1'b0;
  int           hold_count = 0;

  // Predicted scan state.
  logic [DimW-1:0]   width_reg;
  logic [DimW-1:0]   height_reg;
  logic [ColW-1:0]   col_pos;
  logic [RowW-1:0]   row_pos;
  logic [IndexW-1:0] cells_seen;
  logic [CountW-1:0] valid_sum;
  logic [CountW-1:0] comb_sum;
  longint unsigned   nearest_dist;
  bit                nearest_found;
  logic [ColW-1:0]   nearest_col;
  logic [RowW-1:0]   nearest_row;
  bit                bad_seen;
  logic [BadW-1:0]   bad_pos;

  function automatic int unsigned grid_dim(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return 32'(v);
  endfunction

  function automatic bit is_fuel_code(logic [CodeW-1:0] code);
    foreach (FuelTable[i]) begin
      if (FuelTable[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_scan();
    col_pos = '0;
    row_pos = '0;
    cells_seen = '0;
    valid_sum = '0;
    comb_sum = '0;
    nearest_dist = 64'h7FF_FFFF;
    nearest_found = 1'b0;
    nearest_col = '0;
    nearest_row = '0;
    bad_seen = 1'b0;
    bad_pos = '0;
  endfunction

  function automatic void scan_cell(logic [CodeW-1:0] code, logic last);
    int unsigned     w;
    int unsigned     h;
    longint unsigned cells;
    longint unsigned sq_dist;
    longint          dx;
    longint          dy;
    grid_report_t    rep;
    w = grid_dim(width_reg);
    h = grid_dim(height_reg);
    cells = longint'(w) * longint'(h);
    if (longint'(cells_seen) < cells) begin
      if (!is_fuel_code(code)) begin
        if (!bad_seen) begin
          bad_seen = 1'b1;
          bad_pos = cells_seen[BadW-1:0];
        end
      end else begin
        if (code != '0) valid_sum++;
        if (code >= Combustible) begin
          dx = 2 * longint'(col_pos) - (longint'(w) - 1);
          dy = 2 * longint'(row_pos) - (longint'(h) - 1);
          sq_dist = dx * dx + dy * dy;
          comb_sum++;
          if (sq_dist < nearest_dist) begin
            nearest_dist = sq_dist;
            nearest_found = 1'b1;
            nearest_col = col_pos;
            nearest_row = row_pos;
          end
        end
      end
      if (longint'(col_pos) + 1 >= w) begin
        col_pos = '0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end
    if (cells_seen != IndexMax) cells_seen++;
    if (last) begin
      if (cells > CellLimit) rep.status = ST_COUNT;
      else if (bad_seen) rep.status = ST_UNKNOWN;
      else if (longint'(cells_seen) != cells) rep.status = ST_COUNT;
      else if (comb_sum == '0) rep.status = ST_NO_FUEL;
      else rep.status = ST_OK;
      rep.valid_count = valid_sum;
      rep.combustible_count = comb_sum;
      rep.seed_x = nearest_found ? nearest_col : '0;
      rep.seed_y = nearest_found ? nearest_row[ColW-1:0] : '0;
      rep.bad_index = (rep.status == ST_UNKNOWN) ? bad_pos : '0;
      due_reports.insert(due_reports.size(), rep);
      clear_scan();
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    grid_cell_t nxt;
    if (rst) begin
      cells_if.valid <= 1'b0;
    end else begin
      if (cells_if.valid && cells_if.ready) scan_cell(cells_if.fuel_code, cells_if.last_cell);
      if (!cells_if.valid || cells_if.ready) begin
        if (pending_cells.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = pending_cells.pop_front();
          cells_if.valid <= 1'b1;
          cells_if.fuel_code <= nxt.code;
          cells_if.last_cell <= nxt.last;
        end else begin
          cells_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (pressure_on && !pressure_done) begin
      if (hold_count == StallCycles) pressure_done <= 1'b1;
      else hold_count <= hold_count + 1;
    end
  end

  always @(posedge clk) begin
    grid_report_t want;
    if (rst) begin
      report_if.ready <= 1'b0;
    end else begin
      if (report_if.valid && report_if.ready) begin
        if (due_reports.size() == 0) begin
          errors++;
          $display("%0t: report with none expected, status %0d", $time, report_if.status);
        end else begin
          want = due_reports.pop_front();
          check_field("status", want.status, report_if.status);
          check_field("valid_count", want.valid_count, report_if.valid_count);
          check_field("combustible_count", want.combustible_count,
                      report_if.combustible_count);
          check_field("seed_x", want.seed_x, report_if.seed_x);
          check_field("seed_y", want.seed_y, report_if.seed_y);
          check_field("bad_index", want.bad_index, report_if.bad_index);
        end
      end
      report_if.ready <= !(pressure_on && !pressure_done) &&
                         ($urandom_range(0, 99) >= take_gap_pct);
    end
  end

  task automatic push_cell(logic [CodeW-1:0] code, logic last);
    grid_cell_t item;
    item = '{code: code, last: last};
    pending_cells.insert(pending_cells.size(), item);
    cells_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cells.size() != 0 || cells_if.valid || due_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_dims(logic [DimW-1:0] w, logic [DimW-1:0] h);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w;
    width_reg = w;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= h;
    height_reg = h;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CodeW-1:0] pick_code(fuel_mix_t mix);
    case (mix)
      MIX_NO_FUEL: return FuelTable[$urandom_range(0, 4)];
      MIX_NOISY: begin
        if ($urandom_range(0, 9) == 0) return CodeW'($urandom_range(0, 65535));
        return FuelTable[$urandom_range(0, 21)];
      end
      default: begin
        if ($urandom_range(0, 99) < 15) return '0;
        return FuelTable[$urandom_range(0, 21)];
      end
    endcase
  endfunction

  task automatic queue_grid(int unsigned n, fuel_mix_t mix, bit close);
    for (int unsigned i = 0; i < n; i++) push_cell(pick_code(mix), close && (i == n - 1));
  endtask

  task automatic random_phase();
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    int unsigned     cells;
    int unsigned     len;
    int unsigned     pick;
    fuel_mix_t       mix;
    bit              close;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w = DimW'($urandom_range(1, 6));
      h = DimW'($urandom_range(1, 6));
    end else if (pick < 80) begin
      w = DimW'($urandom_range(1, 24));
      h = DimW'($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 1) begin
        h = w;
        w = DimW'($urandom_range(1, 3));
      end
    end else if (pick < 90) begin
      w = DimW'($urandom_range(0, 6));
      h = '0;
      if ($urandom_range(0, 1) == 1) begin
        h = w;
        w = '0;
      end
    end else begin
      w = ($urandom_range(0, 1) == 1) ? DimW'(MaxDim) : DimW'($urandom_range(4097, 8191));
      h = DimW'($urandom_range(1, 8191));
    end
    set_dims(w, h);
    cells = grid_dim(w) * grid_dim(h);
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 99);
      mix = (pick < 60) ? MIX_CLEAN : (pick < 75) ? MIX_NO_FUEL : MIX_NOISY;
      close = 1'b1;
      pick = $urandom_range(0, 99);
      if (cells > 64) begin
        len = $urandom_range(1, 12);
      end else if (pick < 75) begin
        len = cells;
      end else if (pick < 85) begin
        len = (cells > 1) ? $urandom_range(1, cells - 1) : cells + 1;
      end else if (pick < 95) begin
        len = cells + $urandom_range(1, 4);
      end else begin
        len = $urandom_range(1, cells);
        close = 1'b0;
      end
      queue_grid(len, mix, close);
    end
  endtask

  initial begin
    cells_if.valid = 1'b0;
    cells_if.fuel_code = '0;
    cells_if.last_cell = 1'b0;
    report_if.ready = 1'b0;
    width_reg = DimW'(1);
    height_reg = DimW'(1);
    clear_scan();
    send_gap_pct = 17;
    take_gap_pct = 58;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-cell grids on the reset dimensions.
    push_cell(16'd183, 1'b1);
    push_cell(16'd0, 1'b1);
    push_cell(16'hFFFF, 1'b1);
    push_cell(16'd91, 1'b1);

    // Three by two: a tie at equal distance keeps the first cell, unknown code on the last.
    set_dims(DimW'(3), DimW'(2));
    push_cell(16'd104, 1'b0);
    push_cell(16'd142, 1'b0);
    push_cell(16'd93, 1'b0);
    push_cell(16'd98, 1'b0);
    push_cell(16'd183, 1'b0);
    push_cell(16'd1, 1'b1);
    // Short grid, then a long one whose extra cells carry an unknown and a combustible code.
    push_cell(16'd102, 1'b0);
    push_cell(16'd0, 1'b0);
    push_cell(16'd165, 1'b0);
    push_cell(16'd109, 1'b1);
    push_cell(16'd0, 1'b0);
    push_cell(16'd92, 1'b0);
    repeat (4) push_cell(16'd0, 1'b0);
    push_cell(16'd7, 1'b0);
    push_cell(16'd148, 1'b1);

    // A grid above the cell limit.
    set_dims(DimW'(MaxDim), DimW'(MaxDim));
    push_cell(16'd183, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 17 : (mode == 1) ? 58 : 0;
      take_gap_pct = (mode == 0) ? 58 : (mode == 1) ? 17 : 0;
      if (mode == 2) begin
        set_dims(DimW'(1), DimW'(1));
        pressure_on = 1'b1;
        repeat (40) push_cell(pick_code(MIX_CLEAN), 1'b1);
      end
      while (cells_sent < 23 + 40 * (mode == 2) + 270 * (mode + 1)) random_phase();
    end

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
